### design/cbema_pkg.sv
// Shared types and codes for the checked big-endian memory access core.
`default_nettype none
package cbema_pkg;

    localparam int DATA_W = 32;
    localparam int CFG_W  = 17;

    // Result status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FAULT   = 2'd2;

    // Operation codes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Access size codes (size three is handled as a long)
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_WORD = 2'd1;
    localparam logic [1:0] SZ_LONG = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_ENV_TOP   = 2'd0;
    localparam logic [1:0] CFG_MEM_LIMIT = 2'd1;
    localparam logic [1:0] CFG_IO_PASS   = 2'd2;

    localparam logic [CFG_W-1:0] MEM_LIMIT_RST = 17'h10000;

    // I/O and ROM window: masked address at or above 0xC00000
    localparam logic [1:0] IO_WINDOW_TOP = 2'b11;

    typedef struct packed {
        logic       pass;
        logic [1:0] status;
    } t_chk_res;

endpackage
`default_nettype wire

### design/cbema_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none
module cbema_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule
`default_nettype wire

### design/cbema_check.sv
// Region and privilege check of the start address of one access.
`default_nettype none
module cbema_check
    import cbema_pkg::*;
#(
    parameter int MEM_BYTES = 65536
) (
    input  wire logic [DATA_W-1:0] i_address,
    input  wire logic              i_supervisor,
    input  wire logic [CFG_W-1:0]  i_env_top,
    input  wire logic [CFG_W-1:0]  i_mem_limit,
    input  wire logic              i_io_pass,
    output t_chk_res               o_res
);

    localparam logic [DATA_W-1:0] MemBytes32 = DATA_W'(MEM_BYTES);

    logic [DATA_W-1:0] limit;
    logic [DATA_W-1:0] env_top;
    logic [DATA_W-1:0] masked;
    logic              in_open;

    always_comb begin
        env_top = {{(DATA_W-CFG_W){1'b0}}, i_env_top};
        limit   = {{(DATA_W-CFG_W){1'b0}}, i_mem_limit};
        if (limit > MemBytes32) begin
            limit = MemBytes32;
        end
        masked  = {8'h00, i_address[23:0]};
        in_open = (i_address >= env_top) && (i_address < limit);

        o_res.pass   = 1'b1;
        o_res.status = ST_DONE;
        if (!in_open) begin
            if (masked[23:22] == IO_WINDOW_TOP) begin
                o_res.pass   = 1'b0;
                o_res.status = i_io_pass ? ST_IGNORED : ST_FAULT;
            end else if (!i_supervisor || masked >= limit) begin
                o_res.pass   = 1'b0;
                o_res.status = ST_FAULT;
            end
        end
    end

endmodule
`default_nettype wire

### design/checked_big_endian_memory_access_core.sv
// Top level: sequencer that walks one access a byte at a time through the byte store.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------------------
//  in      | input     | i_in_valid / o_in_stall | i_op i_address i_write_data i_size
//          |           |                         | i_supervisor
//  out     | output    | o_out_valid/i_out_stall | o_read_data o_status
//  cfg     | input     | i_cfg_we (no wait)      | i_cfg_index i_cfg_data
//
// An item passes through accept (S_IDLE), check (S_CHECK), one S_RUN step per
// byte (1, 2 or 4) and, for a read, S_DRAIN for the last registered read, before
// the result shows in S_DONE; an ignored or faulted item goes from the check
// straight to its result. The single byte port of the store paces the byte walk.
// The block takes no new item until its result is taken; o_out_valid holds while
// i_out_stall is high. Reset is synchronous; the byte store is not cleared.
`default_nettype none
module checked_big_endian_memory_access_core
    import cbema_pkg::*;
#(
    parameter int MEM_BYTES = 65536
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic              i_op,
    input  wire logic [DATA_W-1:0] i_address,
    input  wire logic [DATA_W-1:0] i_write_data,
    input  wire logic [1:0]        i_size,
    input  wire logic              i_supervisor,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic      [DATA_W-1:0] o_read_data,
    output logic      [1:0]        o_status,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [CFG_W-1:0]  i_cfg_data
);

    localparam int AW = $clog2(MEM_BYTES);
    localparam logic [AW-1:0] LastIdx = AW'(MEM_BYTES - 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_RUN   = 5'b00100,
        S_DRAIN = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [CFG_W-1:0]  r_env_top;
    logic [CFG_W-1:0]  r_mem_limit;
    logic              r_io_pass;

    logic              r_op, n_op;
    logic [DATA_W-1:0] r_addr, n_addr;
    logic [DATA_W-1:0] r_wsh, n_wsh;
    logic              r_sup, n_sup;
    logic [1:0]        r_cnt, n_cnt;
    logic [AW-1:0]     r_ptr, n_ptr;
    logic [DATA_W-1:0] r_acc, n_acc;
    logic [1:0]        r_status, n_status;
    logic              r_rd_pend, n_rd_pend;

    t_chk_res          chk;
    logic              ram_we;
    logic [7:0]        ram_rdata;

    cbema_check #(
        .MEM_BYTES(MEM_BYTES)
    ) u_check (
        .i_address   (r_addr),
        .i_supervisor(r_sup),
        .i_env_top   (r_env_top),
        .i_mem_limit (r_mem_limit),
        .i_io_pass   (r_io_pass),
        .o_res       (chk)
    );

    cbema_ram #(
        .WIDTH(8),
        .DEPTH(MEM_BYTES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (r_ptr),
        .i_wdata(r_wsh[DATA_W-1 -: 8]),
        .o_rdata(ram_rdata)
    );

    assign ram_we      = (r_state == S_RUN) && (r_op == OP_WRITE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_DONE);
    assign o_read_data = r_acc;
    assign o_status    = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env_top   <= '0;
            r_mem_limit <= MEM_LIMIT_RST;
            r_io_pass   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ENV_TOP:   r_env_top   <= i_cfg_data;
                CFG_MEM_LIMIT: r_mem_limit <= i_cfg_data;
                CFG_IO_PASS:   r_io_pass   <= i_cfg_data[0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_addr    = r_addr;
        n_wsh     = r_wsh;
        n_sup     = r_sup;
        n_cnt     = r_cnt;
        n_ptr     = r_ptr;
        n_acc     = r_acc;
        n_status  = r_status;
        n_rd_pend = 1'b0;

        // shift in the byte read in the previous cycle, most significant first
        if (r_rd_pend) begin
            n_acc = {r_acc[DATA_W-9:0], ram_rdata};
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op   = i_op;
                    n_addr = i_address;
                    n_sup  = i_supervisor;
                    case (i_size)
                        SZ_BYTE: begin
                            n_wsh = {i_write_data[7:0], 24'h000000};
                            n_cnt = 2'd0;
                        end
                        SZ_WORD: begin
                            n_wsh = {i_write_data[15:0], 16'h0000};
                            n_cnt = 2'd1;
                        end
                        default: begin
                            n_wsh = i_write_data;
                            n_cnt = 2'd3;
                        end
                    endcase
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_acc    = '0;
                n_status = chk.status;
                n_ptr    = r_addr[AW-1:0];
                n_state  = chk.pass ? S_RUN : S_DONE;
            end
            S_RUN: begin
                n_rd_pend = (r_op == OP_READ);
                n_wsh     = {r_wsh[DATA_W-9:0], 8'h00};
                // bytes past the store end wrap to the start
                n_ptr     = (r_ptr == LastIdx) ? '0 : r_ptr + 1'b1;
                if (r_cnt == 2'd0) begin
                    n_state = (r_op == OP_WRITE) ? S_DONE : S_DRAIN;
                end else begin
                    n_cnt = r_cnt - 2'd1;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= n_rd_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_addr   <= n_addr;
        r_wsh    <= n_wsh;
        r_sup    <= n_sup;
        r_cnt    <= n_cnt;
        r_ptr    <= n_ptr;
        r_acc    <= n_acc;
        r_status <= n_status;
    end

`ifndef NO_ASSERTIONS
    a_ready_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !o_out_valid)
        else $error("input ready while a result is pending");

    a_drain_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> (r_op == OP_READ) && !r_rd_pend == 1'b0)
        else $error("drain cycle without a pending read");

    a_store_only_passed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_status == ST_DONE))
        else $error("store written by an ignored or faulted item");

    a_reject_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_DONE)) |-> (o_read_data == '0))
        else $error("ignored or faulted item returns data");

    a_check_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CHECK) && !chk.pass) |=> o_out_valid)
        else $error("rejected item did not go straight to its result");
`endif

endmodule
`default_nettype wire
